@@ rtl/chd_pkg.sv @@
package chd_pkg;

  localparam int NUM_FKEYS = 12;

  localparam int CODE_W  = 5;
  localparam int KIND_W  = 2;
  localparam int TERM_W  = 4;
  localparam int NUM_MOD = 4;

  localparam logic [CODE_W-1:0] CODE_LCTRL = 5'd1;
  localparam logic [CODE_W-1:0] CODE_RCTRL = 5'd2;
  localparam logic [CODE_W-1:0] CODE_LALT  = 5'd3;
  localparam logic [CODE_W-1:0] CODE_RALT  = 5'd4;
  localparam logic [CODE_W-1:0] CODE_BKSP  = 5'd5;
  localparam logic [CODE_W-1:0] CODE_F1    = 5'd6;

  localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SHUTDOWN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SWITCH   = 2'd2;

  typedef struct packed {
    logic              is_key_event;
    logic [CODE_W-1:0] key_code;
    logic              pressed;
    logic              auto_repeat;
  } key_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] shortcut_kind;
    logic [TERM_W-1:0] terminal_number;
    logic              consumed;
  } hotkey_result_t;

endpackage

@@ rtl/chd_in_if.sv @@
interface chd_in_if;
  import chd_pkg::*;

  logic              valid;
  logic              ready;
  logic              is_key_event;
  logic [CODE_W-1:0] key_code;
  logic              pressed;
  logic              auto_repeat;

  modport source (output valid, output is_key_event, output key_code, output pressed,
                  output auto_repeat, input ready);
  modport sink (input valid, input is_key_event, input key_code, input pressed,
                input auto_repeat, output ready);
endinterface

@@ rtl/chd_out_if.sv @@
interface chd_out_if;
  import chd_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] shortcut_kind;
  logic [TERM_W-1:0] terminal_number;
  logic              consumed;

  modport source (output valid, output shortcut_kind, output terminal_number,
                  output consumed, input ready);
  modport sink (input valid, input shortcut_kind, input terminal_number,
                input consumed, output ready);
endinterface

@@ rtl/chd_in_stage.sv @@
module chd_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  chd_in_if.sink            in_ch,
  input  logic              advance,
  output logic              item_valid,
  output chd_pkg::key_item_t item
);
  import chd_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  key_item_t item_r;
  logic      take;

  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;
  assign valid_nxt   = take ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.is_key_event <= in_ch.is_key_event;
      item_r.key_code     <= in_ch.key_code;
      item_r.pressed      <= in_ch.pressed;
      item_r.auto_repeat  <= in_ch.auto_repeat;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;
endmodule

@@ rtl/chd_key_state.sv @@
module chd_key_state (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  chd_pkg::key_item_t      item,
  output chd_pkg::hotkey_result_t result
);
  import chd_pkg::*;

  logic [NUM_MOD-1:0]   mod_r, mod_nxt;
  logic                 bs_held_r, bs_held_nxt;
  logic                 bs_sw_r, bs_sw_nxt;
  logic [NUM_FKEYS-1:0] fheld_r, fheld_nxt;
  logic [NUM_FKEYS-1:0] fsw_r, fsw_nxt;

  logic [NUM_MOD-1:0]   mod_bit;
  logic [NUM_FKEYS-1:0] f_bit;
  logic                 is_mod;
  logic                 is_fkey;
  logic                 combo;
  logic                 f_held_hit;
  logic                 f_sw_hit;

  always_comb begin
    for (int i = 0; i < NUM_MOD; i++) begin
      mod_bit[i] = (item.key_code == CODE_W'(CODE_LCTRL + CODE_W'(i)));
    end
    for (int i = 0; i < NUM_FKEYS; i++) begin
      f_bit[i] = (item.key_code == CODE_W'(CODE_F1 + CODE_W'(i)));
    end
  end

  assign is_mod     = |mod_bit;
  assign is_fkey    = |f_bit;
  assign combo      = (|mod_r[1:0]) && (|mod_r[3:2]);
  assign f_held_hit = |(fheld_r & f_bit);
  assign f_sw_hit   = |(fsw_r & f_bit);

  always_comb begin
    mod_nxt     = mod_r;
    bs_held_nxt = bs_held_r;
    bs_sw_nxt   = bs_sw_r;
    fheld_nxt   = fheld_r;
    fsw_nxt     = fsw_r;
    result      = '0;
    if (item.is_key_event) begin
      if (is_mod) begin
        mod_nxt = item.pressed ? (mod_r | mod_bit) : (mod_r & ~mod_bit);
      end else if (item.key_code == CODE_BKSP) begin
        if (!item.pressed) begin
          result.consumed = bs_sw_r;
          bs_held_nxt     = 1'b0;
          bs_sw_nxt       = 1'b0;
        end else if (bs_held_r || item.auto_repeat) begin
          bs_held_nxt     = 1'b1;
          result.consumed = bs_sw_r;
        end else begin
          bs_held_nxt = 1'b1;
          if (combo) begin
            bs_sw_nxt            = 1'b1;
            result.shortcut_kind = KIND_SHUTDOWN;
            result.consumed      = 1'b1;
          end
        end
      end else if (is_fkey) begin
        if (!item.pressed) begin
          result.consumed = f_sw_hit;
          fheld_nxt       = fheld_r & ~f_bit;
          fsw_nxt         = fsw_r & ~f_bit;
        end else if (f_held_hit || item.auto_repeat) begin
          result.consumed = f_sw_hit;
          fheld_nxt       = fheld_r | f_bit;
        end else begin
          fheld_nxt = fheld_r | f_bit;
          if (combo) begin
            fsw_nxt                = fsw_r | f_bit;
            result.shortcut_kind   = KIND_SWITCH;
            result.terminal_number = TERM_W'(item.key_code - CODE_F1 + CODE_W'(1));
            result.consumed        = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r     <= '0;
      bs_held_r <= 1'b0;
      bs_sw_r   <= 1'b0;
      fheld_r   <= '0;
      fsw_r     <= '0;
    end else if (step) begin
      mod_r     <= mod_nxt;
      bs_held_r <= bs_held_nxt;
      bs_sw_r   <= bs_sw_nxt;
      fheld_r   <= fheld_nxt;
      fsw_r     <= fsw_nxt;
    end
  end
endmodule

@@ rtl/chd_out_stage.sv @@
module chd_out_stage (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    item_valid,
  input  chd_pkg::hotkey_result_t result,
  output logic                    advance,
  chd_out_if.source               out_ch
);
  import chd_pkg::*;

  logic           valid_r;
  logic           valid_nxt;
  hotkey_result_t res_r;

  assign advance   = item_valid && (!valid_r || out_ch.ready);
  assign valid_nxt = advance ? 1'b1 : ((valid_r && out_ch.ready) ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= result;
    end
  end

  assign out_ch.valid           = valid_r;
  assign out_ch.shortcut_kind   = res_r.shortcut_kind;
  assign out_ch.terminal_number = res_r.terminal_number;
  assign out_ch.consumed        = res_r.consumed;
endmodule

@@ rtl/console_hotkey_detector.sv @@
// console hotkey detector
// in_ch: one key event per request (is_key_event, key_code, pressed, auto_repeat)
// out_ch: exactly one result per input request (shortcut_kind, terminal_number, consumed)
// an event is registered at the input, decoded against the modifier, backspace
// and function key flags, and the result is registered at the output
// throughput: one event per cycle while out_ch is not stalled, set by the single decode
// and flag update step between the input register and the result register
// flags update at the moment an event moves into the result register
// a stalled out_ch holds its result; one more event waits in the input register,
// then in_ch.ready drops until the result is taken
// reset (synchronous, rst_n low) clears all modifier, held and consumed flags
// and empties both registers
module console_hotkey_detector (
  input  logic      clk,
  input  logic      rst_n,
  chd_in_if.sink    in_ch,
  chd_out_if.source out_ch
);
  import chd_pkg::*;

  logic           s1_valid;
  key_item_t      s1_item;
  logic           s1_advance;
  hotkey_result_t s1_result;

  chd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (s1_advance),
    .item_valid (s1_valid),
    .item       (s1_item)
  );

  chd_key_state u_key_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_advance),
    .item   (s1_item),
    .result (s1_result)
  );

  chd_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s1_valid),
    .result     (s1_result),
    .advance    (s1_advance),
    .out_ch     (out_ch)
  );

`ifndef SYNTHESIS
  a_switch_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.shortcut_kind == KIND_SWITCH) |->
      (out_ch.consumed && out_ch.terminal_number != '0))
    else $error("switch result without consume or terminal");

  a_term_only_switch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.shortcut_kind != KIND_SWITCH) |->
      (out_ch.terminal_number == '0))
    else $error("terminal number set outside a switch");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid |-> in_ch.ready)
    else $error("input not ready with empty input register");

  a_advance_loads: assert property (@(posedge clk) disable iff (!rst_n)
    s1_advance |=> out_ch.valid)
    else $error("advanced event did not reach the result register");
`endif
endmodule
